// File: rtl/core/pwsd_pkg.sv
`timescale 1ns / 1ps
// pwsd_pkg: shared constants, register indexes and helper functions for the
// PID controller with settle detection. No dependencies.
package pwsd_pkg;

    localparam int DATA_WIDTH = 32;
    // saturation width of error, derivative and drive
    localparam int SAT_W = (DATA_WIDTH > 32) ? 32 : ((DATA_WIDTH < 16) ? 16 : DATA_WIDTH);

    localparam int GAIN_W   = 32;
    localparam int BAND_W   = 31;
    localparam int EXIT_W   = 48;
    localparam int INT_W    = 48;
    localparam int TIMER_W  = 16;
    localparam int PROD_W   = 64;
    localparam int WIDE_W   = 80;
    localparam int CFG_IDX_W = 4;

    localparam logic [CFG_IDX_W-1:0] REG_KP         = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KI         = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KD         = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INT_WINDOW = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SMALL_BAND = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LARGE_BAND = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_BAND  = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_EXIT_TICKS = 4'd7;

    // clamp a wide signed value to SAT_W bits, returned sign-extended to 32 bits
    function automatic logic signed [31:0] sat_data(input logic signed [WIDE_W-1:0] x);
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        hi = $signed((WIDE_W'(1) << (SAT_W - 1)) - WIDE_W'(1));
        lo = -hi - WIDE_W'(1);
        if (x > hi) begin
            return hi[31:0];
        end else if (x < lo) begin
            return lo[31:0];
        end
        return x[31:0];
    endfunction

    // saturating tick count
    function automatic logic [TIMER_W-1:0] bump(input logic [TIMER_W-1:0] t);
        return (t == {TIMER_W{1'b1}}) ? t : t + TIMER_W'(1);
    endfunction

    // magnitude of a 32-bit signed value, as unsigned
    function automatic logic [31:0] mag32(input logic signed [31:0] x);
        return x[31] ? 32'(-x) : x;
    endfunction

endpackage

// File: rtl/core/pid_with_settle_detect.sv
`timescale 1ns / 1ps
// pid_with_settle_detect: discrete Q16.16 PID controller with settle timers.
// Depends on pwsd_pkg.
//
// Takes one tick per clock while s_ready is high and returns one result per
// tick, in order. The six stages are: error subtract, error band compares,
// state update (derivative, integral, timers, settled), the four 32-bit
// gain products, two partial sums, and the final sum with floor shift and
// saturation into the output register. Only the state update stage holds
// loop-carried state, so ticks may arrive in consecutive cycles. Each stage
// advances on its own when the stage after it is empty or moving, so input
// transfers continue while a result waits on m_ready until the pipe is full.
// Configuration writes are always accepted (cfg_ready is tied high) and
// should only be made while no tick is in flight. op = 1 clears the state
// and returns an all-zero result.
module pid_with_settle_detect (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [pwsd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pwsd_pkg::EXIT_W-1:0]        cfg_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_op,
    input  logic signed [31:0]                 s_measured,
    input  logic signed [31:0]                 s_setpoint,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [31:0]                 m_drive,
    output logic signed [31:0]                 m_error_now,
    output logic                               m_settled
);
    import pwsd_pkg::*;

    // configuration
    logic signed [GAIN_W-1:0] kp_reg, ki_reg, kd_reg;
    logic [BAND_W-1:0]        int_window_reg, small_band_reg, large_band_reg, rate_band_reg;
    logic [EXIT_W-1:0]        exit_ticks_reg;

    // controller state
    logic signed [31:0]       last_error_reg, last_error_next;
    logic signed [INT_W-1:0]  integral_reg, integral_next;
    logic [TIMER_W-1:0]       small_timer_reg, small_timer_next;
    logic [TIMER_W-1:0]       large_timer_reg, large_timer_next;
    logic [TIMER_W-1:0]       rate_timer_reg, rate_timer_next;

    // stage valids and advance enables
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic en1, en2, en3, en4, en5, en6;

    // stage payloads
    logic                     op1_reg, op2_reg;
    logic signed [31:0]       e1_reg, e2_reg, e3_reg, e4_reg, e5_reg;
    logic                     win2_reg, small2_reg, large2_reg;
    logic signed [31:0]       d3_reg;
    logic signed [INT_W-1:0]  int3_reg;
    logic                     st3_reg, st4_reg, st5_reg;
    logic signed [PROD_W-1:0] p4_reg, q4_reg, kih4_reg;
    logic signed [48:0]       l4_reg;
    logic signed [PROD_W:0]   sa5_reg;
    logic signed [WIDE_W-1:0] sb5_reg;
    logic signed [31:0]       drive_reg, error_out_reg;
    logic                     settled_reg;

    // combinational stage values
    logic signed [31:0]       e1_next;
    logic [31:0]              abs_e2;
    logic signed [31:0]       e3_next, d3_next;
    logic signed [INT_W-1:0]  int3_next;
    logic                     st3_next;
    logic signed [32:0]       d_full;
    logic signed [31:0]       d_sat;
    logic [31:0]              abs_d;
    logic signed [INT_W:0]    int_sum;
    logic signed [INT_W-1:0]  int_added;
    logic                     sign_change;
    logic signed [PROD_W-1:0] p4_next, q4_next, kih4_next;
    logic signed [48:0]       l4_next;
    logic signed [31:0]       ih3;
    logic signed [16:0]       il3;
    logic signed [PROD_W:0]   sa5_next;
    logic signed [WIDE_W-1:0] l_ext, kih_ext, sb5_next;
    logic signed [WIDE_W:0]   total;
    logic signed [WIDE_W:0]   total_sh;
    logic signed [31:0]       drive_next;

    // ---------------- flow control ----------------
    assign en6 = !v6_reg || m_ready;
    assign en5 = !v5_reg || en6;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;

    assign s_ready   = en1;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= s_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
            if (en6) v6_reg <= v5_reg;
        end
    end

    // ---------------- configuration ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kp_reg         <= '0;
            ki_reg         <= '0;
            kd_reg         <= '0;
            int_window_reg <= '0;
            small_band_reg <= '0;
            large_band_reg <= '0;
            rate_band_reg  <= '0;
            exit_ticks_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_KP:         kp_reg         <= cfg_data[GAIN_W-1:0];
                REG_KI:         ki_reg         <= cfg_data[GAIN_W-1:0];
                REG_KD:         kd_reg         <= cfg_data[GAIN_W-1:0];
                REG_INT_WINDOW: int_window_reg <= cfg_data[BAND_W-1:0];
                REG_SMALL_BAND: small_band_reg <= cfg_data[BAND_W-1:0];
                REG_LARGE_BAND: large_band_reg <= cfg_data[BAND_W-1:0];
                REG_RATE_BAND:  rate_band_reg  <= cfg_data[BAND_W-1:0];
                REG_EXIT_TICKS: exit_ticks_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- stage 1: error ----------------
    assign e1_next = sat_data(WIDE_W'($signed({s_setpoint[31], s_setpoint})
                                      - $signed({s_measured[31], s_measured})));

    always_ff @(posedge aclk) begin
        if (en1) begin
            op1_reg <= s_op;
            e1_reg  <= e1_next;
        end
    end

    // ---------------- stage 2: error band compares ----------------
    assign abs_e2 = mag32(e1_reg);

    always_ff @(posedge aclk) begin
        if (en2) begin
            op2_reg    <= op1_reg;
            e2_reg     <= e1_reg;
            win2_reg   <= abs_e2 < {1'b0, int_window_reg};
            small2_reg <= abs_e2 < {1'b0, small_band_reg};
            large2_reg <= abs_e2 < {1'b0, large_band_reg};
        end
    end

    // ---------------- stage 3: state update ----------------
    always_comb begin
        d_full    = $signed({e2_reg[31], e2_reg}) - $signed({last_error_reg[31], last_error_reg});
        d_sat     = sat_data(WIDE_W'(d_full));
        abs_d     = mag32(d_sat);
        int_sum   = $signed({integral_reg[INT_W-1], integral_reg})
                    + (INT_W + 1)'(e2_reg);
        // 48-bit saturation: overflow when the two top bits disagree
        if (int_sum[INT_W] != int_sum[INT_W-1]) begin
            int_added = int_sum[INT_W] ? {1'b1, {(INT_W - 1){1'b0}}}
                                       : {1'b0, {(INT_W - 1){1'b1}}};
        end else begin
            int_added = int_sum[INT_W-1:0];
        end
        // sign of zero counts as its own sign
        sign_change = (e2_reg[31] != last_error_reg[31])
                      || ((e2_reg == '0) != (last_error_reg == '0));

        integral_next = integral_reg;
        if (ki_reg != '0) begin
            if (win2_reg) integral_next = int_added;
            if (sign_change) integral_next = '0;
        end

        small_timer_next = small2_reg ? bump(small_timer_reg) : small_timer_reg;
        large_timer_next = large2_reg ? bump(large_timer_reg) : large_timer_reg;
        rate_timer_next  = (abs_d < {1'b0, rate_band_reg}) ? bump(rate_timer_reg) : '0;
        last_error_next  = e2_reg;

        st3_next = (small_timer_next > exit_ticks_reg[15:0])
                   || (large_timer_next > exit_ticks_reg[31:16])
                   || (rate_timer_next > exit_ticks_reg[47:32]);
        e3_next   = e2_reg;
        d3_next   = d_sat;
        int3_next = integral_next;

        if (op2_reg) begin
            integral_next    = '0;
            small_timer_next = '0;
            large_timer_next = '0;
            rate_timer_next  = '0;
            last_error_next  = '0;
            st3_next         = 1'b0;
            e3_next          = '0;
            d3_next          = '0;
            int3_next        = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_error_reg  <= '0;
            integral_reg    <= '0;
            small_timer_reg <= '0;
            large_timer_reg <= '0;
            rate_timer_reg  <= '0;
        end else if (en3 && v2_reg) begin
            last_error_reg  <= last_error_next;
            integral_reg    <= integral_next;
            small_timer_reg <= small_timer_next;
            large_timer_reg <= large_timer_next;
            rate_timer_reg  <= rate_timer_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en3) begin
            e3_reg   <= e3_next;
            d3_reg   <= d3_next;
            int3_reg <= int3_next;
            st3_reg  <= st3_next;
        end
    end

    // ---------------- stage 4: products ----------------
    // integral split as ih*2^16 + il, il unsigned
    assign ih3       = int3_reg[INT_W-1:16];
    assign il3       = $signed({1'b0, int3_reg[15:0]});
    assign p4_next   = PROD_W'(kp_reg) * PROD_W'(e3_reg);
    assign q4_next   = PROD_W'(kd_reg) * PROD_W'(d3_reg);
    assign kih4_next = PROD_W'(ki_reg) * PROD_W'(ih3);
    assign l4_next   = 49'(ki_reg) * 49'(il3);

    always_ff @(posedge aclk) begin
        if (en4) begin
            p4_reg   <= p4_next;
            q4_reg   <= q4_next;
            kih4_reg <= kih4_next;
            l4_reg   <= l4_next;
            e4_reg   <= e3_reg;
            st4_reg  <= st3_reg;
        end
    end

    // ---------------- stage 5: partial sums (Q32.32) ----------------
    assign sa5_next = (PROD_W + 1)'(p4_reg) + (PROD_W + 1)'(q4_reg);
    assign l_ext    = WIDE_W'(l4_reg);
    assign kih_ext  = WIDE_W'(kih4_reg);
    assign sb5_next = l_ext + (kih_ext <<< 16);

    always_ff @(posedge aclk) begin
        if (en5) begin
            sa5_reg <= sa5_next;
            sb5_reg <= sb5_next;
            e5_reg  <= e4_reg;
            st5_reg <= st4_reg;
        end
    end

    // ---------------- stage 6: floor to Q16.16 and saturate ----------------
    assign total      = (WIDE_W + 1)'(sa5_reg) + (WIDE_W + 1)'(sb5_reg);
    assign total_sh   = total >>> 16;
    assign drive_next = sat_data(total_sh[WIDE_W-1:0]);

    always_ff @(posedge aclk) begin
        if (en6) begin
            drive_reg     <= drive_next;
            error_out_reg <= e5_reg;
            settled_reg   <= st5_reg;
        end
    end

    assign m_valid     = v6_reg;
    assign m_drive     = drive_reg;
    assign m_error_now = error_out_reg;
    assign m_settled   = settled_reg;

endmodule
